[src/trbr_pkg.sv]
// trbr_pkg: shared constants for the translocation breakpoint remap block
// holds default widths, configuration register indexes and orientation codes
// no dependencies
package trbr_pkg;

  // default field widths
  localparam int REF_ID_BITS_DEF = 10;
  localparam int POS_BITS_DEF    = 31;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REF_FIRST   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POS_FIRST   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REF_SECOND  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POS_SECOND  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_FIRST  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_SECOND = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEN_FIRST   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEN_SECOND  = 3'd7;

  // orientation cases, coded as {side_first, side_second}
  localparam logic [1:0] ORIENT_FF = 2'b00;
  localparam logic [1:0] ORIENT_FR = 2'b01;
  localparam logic [1:0] ORIENT_RF = 2'b10;
  localparam logic [1:0] ORIENT_RR = 2'b11;

endpackage

[src/translocation_breakpoint_remap.sv]
// translocation_breakpoint_remap: remaps translocation endpoints through one
// applied translocation; input register, two remap units, result register
// depends on trbr_pkg, trbr_cfg and trbr_remap
// an accepted request is held in the input register and then in the result
// register, whose valid flag drives out_tvalid
// throughput: one request per cycle, set by the single pass between the input
// register and the result register; a stalled result blocks intake only once
// the input register is also full
// reset (synchronous, rst_n low) empties both stages and clears all
// configuration registers to 0
module translocation_breakpoint_remap #(
  parameter int REF_ID_BITS = trbr_pkg::REF_ID_BITS_DEF,
  parameter int POS_BITS    = trbr_pkg::POS_BITS_DEF,
  parameter int CFG_BITS    = (REF_ID_BITS > POS_BITS) ? REF_ID_BITS : POS_BITS,
  parameter int TDATA_BITS  = ((2 * (REF_ID_BITS + POS_BITS) + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [trbr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: in_ref_a, in_pos_a, in_ref_b, in_pos_b, zero pad
  input  logic [TDATA_BITS-1:0]               in_tdata,
  // in_tuser: in_side_a, in_side_b
  input  logic [1:0]                          in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: out_ref_lo, out_pos_lo, out_ref_hi, out_pos_hi, zero pad
  output logic [TDATA_BITS-1:0]               out_tdata,
  // out_tuser: out_side_lo, out_side_hi, out_of_range
  output logic [2:0]                          out_tuser
);
  import trbr_pkg::*;

  localparam int EpBits = REF_ID_BITS + POS_BITS;
  localparam int PadBits = TDATA_BITS - 2 * EpBits;

  logic [REF_ID_BITS-1:0] ref_first, ref_second;
  logic [POS_BITS-1:0]    pos_first, pos_second, len_first, len_second;
  logic                   side_first, side_second;

  // configuration registers
  trbr_cfg #(
    .REF_ID_BITS (REF_ID_BITS),
    .POS_BITS    (POS_BITS),
    .DATA_BITS   (CFG_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ref_first   (ref_first),
    .pos_first   (pos_first),
    .ref_second  (ref_second),
    .pos_second  (pos_second),
    .side_first  (side_first),
    .side_second (side_second),
    .len_first   (len_first),
    .len_second  (len_second)
  );

  // stage handshake
  logic s1_valid_r, s1_valid_nxt, out_valid_r, out_valid_nxt;
  logic s1_en, s2_en;

  assign s2_en     = !out_valid_r || out_tready;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_tready = s1_en;

  always_comb begin
    s1_valid_nxt  = s1_en ? in_tvalid : s1_valid_r;
    out_valid_nxt = s2_en ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  logic [REF_ID_BITS-1:0] ra_r, rb_r;
  logic [POS_BITS-1:0]    pa_r, pb_r;
  logic                   sa_r, sb_r;

  always_ff @(posedge clk) begin
    if (s1_en && in_tvalid) begin
      ra_r <= in_tdata[REF_ID_BITS-1:0];
      pa_r <= in_tdata[EpBits-1:REF_ID_BITS];
      rb_r <= in_tdata[EpBits+REF_ID_BITS-1:EpBits];
      pb_r <= in_tdata[2*EpBits-1:EpBits+REF_ID_BITS];
      sa_r <= in_tuser[0];
      sb_r <= in_tuser[1];
    end
  end

  // remap both endpoints, B with its side flag inverted
  logic [REF_ID_BITS-1:0] ea_ref, eb_ref;
  logic [POS_BITS-1:0]    ea_pos, eb_pos;
  logic                   ea_oor, eb_oor;

  trbr_remap #(
    .REF_ID_BITS (REF_ID_BITS),
    .POS_BITS    (POS_BITS)
  ) u_remap_a (
    .ref_first   (ref_first),
    .pos_first   (pos_first),
    .ref_second  (ref_second),
    .pos_second  (pos_second),
    .side_first  (side_first),
    .side_second (side_second),
    .len_first   (len_first),
    .len_second  (len_second),
    .ref_in      (ra_r),
    .pos_in      (pa_r),
    .side_in     (sa_r),
    .ref_out     (ea_ref),
    .pos_out     (ea_pos),
    .oor_out     (ea_oor)
  );

  trbr_remap #(
    .REF_ID_BITS (REF_ID_BITS),
    .POS_BITS    (POS_BITS)
  ) u_remap_b (
    .ref_first   (ref_first),
    .pos_first   (pos_first),
    .ref_second  (ref_second),
    .pos_second  (pos_second),
    .side_first  (side_first),
    .side_second (side_second),
    .len_first   (len_first),
    .len_second  (len_second),
    .ref_in      (rb_r),
    .pos_in      (pb_r),
    .side_in     (!sb_r),
    .ref_out     (eb_ref),
    .pos_out     (eb_pos),
    .oor_out     (eb_oor)
  );

  // pass through on exact match, else order by reference id
  logic                   match;
  logic [REF_ID_BITS-1:0] ref_lo_nxt, ref_hi_nxt;
  logic [POS_BITS-1:0]    pos_lo_nxt, pos_hi_nxt;
  logic                   side_lo_nxt, side_hi_nxt, oor_nxt;

  assign match = (ra_r == ref_first) && (pa_r == pos_first) &&
                 (rb_r == ref_second) && (pb_r == pos_second);

  always_comb begin
    if (match) begin
      ref_lo_nxt  = ra_r;
      pos_lo_nxt  = pa_r;
      side_lo_nxt = sa_r;
      ref_hi_nxt  = rb_r;
      pos_hi_nxt  = pb_r;
      side_hi_nxt = sb_r;
      oor_nxt     = 1'b0;
    end else if (ea_ref > eb_ref) begin
      ref_lo_nxt  = eb_ref;
      pos_lo_nxt  = eb_pos;
      side_lo_nxt = sb_r;
      ref_hi_nxt  = ea_ref;
      pos_hi_nxt  = ea_pos;
      side_hi_nxt = sa_r;
      oor_nxt     = ea_oor | eb_oor;
    end else begin
      ref_lo_nxt  = ea_ref;
      pos_lo_nxt  = ea_pos;
      side_lo_nxt = sa_r;
      ref_hi_nxt  = eb_ref;
      pos_hi_nxt  = eb_pos;
      side_hi_nxt = sb_r;
      oor_nxt     = ea_oor | eb_oor;
    end
  end

  // result register
  logic [REF_ID_BITS-1:0] ref_lo_r, ref_hi_r;
  logic [POS_BITS-1:0]    pos_lo_r, pos_hi_r;
  logic                   side_lo_r, side_hi_r, oor_r;

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      ref_lo_r  <= ref_lo_nxt;
      pos_lo_r  <= pos_lo_nxt;
      side_lo_r <= side_lo_nxt;
      ref_hi_r  <= ref_hi_nxt;
      pos_hi_r  <= pos_hi_nxt;
      side_hi_r <= side_hi_nxt;
      oor_r     <= oor_nxt;
    end
  end

  // result stream packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PadBits{1'b0}}, pos_hi_r, ref_hi_r, pos_lo_r, ref_lo_r};
  assign out_tuser  = {oor_r, side_hi_r, side_lo_r};

endmodule

[src/trbr_cfg.sv]
// trbr_cfg: configuration register file of the applied translocation
// depends on trbr_pkg for register indexes
module trbr_cfg #(
  parameter int REF_ID_BITS = trbr_pkg::REF_ID_BITS_DEF,
  parameter int POS_BITS    = trbr_pkg::POS_BITS_DEF,
  parameter int DATA_BITS   = (REF_ID_BITS > POS_BITS) ? REF_ID_BITS : POS_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [trbr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DATA_BITS-1:0]                cfg_data,
  output logic [REF_ID_BITS-1:0]              ref_first,
  output logic [POS_BITS-1:0]                 pos_first,
  output logic [REF_ID_BITS-1:0]              ref_second,
  output logic [POS_BITS-1:0]                 pos_second,
  output logic                                side_first,
  output logic                                side_second,
  output logic [POS_BITS-1:0]                 len_first,
  output logic [POS_BITS-1:0]                 len_second
);
  import trbr_pkg::*;

  logic [REF_ID_BITS-1:0] ref_first_r, ref_second_r;
  logic [POS_BITS-1:0]    pos_first_r, pos_second_r, len_first_r, len_second_r;
  logic                   side_first_r, side_second_r;
  logic                   wr_en;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  // register writes, values truncated to register widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_first_r   <= '0;
      pos_first_r   <= '0;
      ref_second_r  <= '0;
      pos_second_r  <= '0;
      side_first_r  <= 1'b0;
      side_second_r <= 1'b0;
      len_first_r   <= '0;
      len_second_r  <= '0;
    end else if (wr_en) begin
      case (cfg_index)
        REG_REF_FIRST:   ref_first_r   <= cfg_data[REF_ID_BITS-1:0];
        REG_POS_FIRST:   pos_first_r   <= cfg_data[POS_BITS-1:0];
        REG_REF_SECOND:  ref_second_r  <= cfg_data[REF_ID_BITS-1:0];
        REG_POS_SECOND:  pos_second_r  <= cfg_data[POS_BITS-1:0];
        REG_SIDE_FIRST:  side_first_r  <= cfg_data[0];
        REG_SIDE_SECOND: side_second_r <= cfg_data[0];
        REG_LEN_FIRST:   len_first_r   <= cfg_data[POS_BITS-1:0];
        REG_LEN_SECOND:  len_second_r  <= cfg_data[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ref_first   = ref_first_r;
  assign pos_first   = pos_first_r;
  assign ref_second  = ref_second_r;
  assign pos_second  = pos_second_r;
  assign side_first  = side_first_r;
  assign side_second = side_second_r;
  assign len_first   = len_first_r;
  assign len_second  = len_second_r;

endmodule

[src/trbr_remap.sv]
// trbr_remap: remaps one breakpoint endpoint through the applied translocation
// combinational; depends on trbr_pkg for orientation codes
module trbr_remap #(
  parameter int REF_ID_BITS = trbr_pkg::REF_ID_BITS_DEF,
  parameter int POS_BITS    = trbr_pkg::POS_BITS_DEF
) (
  input  logic [REF_ID_BITS-1:0] ref_first,
  input  logic [POS_BITS-1:0]    pos_first,
  input  logic [REF_ID_BITS-1:0] ref_second,
  input  logic [POS_BITS-1:0]    pos_second,
  input  logic                   side_first,
  input  logic                   side_second,
  input  logic [POS_BITS-1:0]    len_first,
  input  logic [POS_BITS-1:0]    len_second,
  input  logic [REF_ID_BITS-1:0] ref_in,
  input  logic [POS_BITS-1:0]    pos_in,
  input  logic                   side_in,
  output logic [REF_ID_BITS-1:0] ref_out,
  output logic [POS_BITS-1:0]    pos_out,
  output logic                   oor_out
);
  import trbr_pkg::*;

  // signed working width, room for a three term sum and a sign
  localparam int W = POS_BITS + 3;

  logic signed [W-1:0] p, p1, p2, l1, l2, one, pos_s;
  logic                on1, on2, lt1, gt1, lt2, gt2, ge2_rf;
  logic [1:0]          orient;

  assign p   = W'(signed'({3'b000, pos_in}));
  assign p1  = W'(signed'({3'b000, pos_first}));
  assign p2  = W'(signed'({3'b000, pos_second}));
  assign l1  = W'(signed'({3'b000, len_first}));
  assign l2  = W'(signed'({3'b000, len_second}));
  assign one = W'(signed'(1));

  // side of each breakpoint the endpoint lies on
  assign on1    = (ref_in == ref_first);
  assign on2    = (ref_in == ref_second);
  assign lt1    = (pos_in < pos_first)  || ((pos_in == pos_first)  && !side_in);
  assign gt1    = (pos_in > pos_first)  || ((pos_in == pos_first)  && side_in);
  assign lt2    = (pos_in < pos_second) || ((pos_in == pos_second) && !side_in);
  assign gt2    = (pos_in > pos_second) || ((pos_in == pos_second) && side_in);
  assign ge2_rf = (pos_in > pos_second) || ((pos_in == pos_second) && !side_in);
  assign orient = {side_first, side_second};

  // orientation case selection and new coordinate
  always_comb begin
    ref_out = ref_in;
    pos_s   = p;
    case (orient)
      ORIENT_RF: begin
        if (on1 && lt1) begin
          ref_out = ref_second;
          pos_s   = p2 + p1 - p - one;
        end else if (on1 && gt1) begin
          ref_out = ref_first;
          pos_s   = l2 - p2 + p - p1;
        end else if (on2 && ge2_rf) begin
          ref_out = ref_first;
          pos_s   = l2 - p - one;
        end
      end
      ORIENT_RR: begin
        if (on1 && lt1) begin
          ref_out = ref_second;
        end else if (on1 && gt1) begin
          ref_out = ref_first;
          pos_s   = p2 + p - p1;
        end else if (on2 && lt2) begin
          ref_out = ref_first;
        end else if (on2 && gt2) begin
          ref_out = ref_second;
          pos_s   = p1 + p - p2;
        end
      end
      ORIENT_FF: begin
        if (on1 && gt1) begin
          ref_out = ref_second;
          pos_s   = p2 + p - p1;
        end else if (on2 && gt2) begin
          ref_out = ref_first;
          pos_s   = p1 + p - p2;
        end
      end
      default: begin
        if (on1 && gt1) begin
          ref_out = ref_second;
          pos_s   = l1 - p - one;
        end else if (on2 && lt2) begin
          ref_out = ref_first;
          pos_s   = p1 + p2 - p - one;
        end else if (on2 && gt2) begin
          ref_out = ref_second;
          pos_s   = l1 - p1 + p - p2;
        end
      end
    endcase
  end

  // saturate to the position range
  always_comb begin
    if (pos_s[W-1]) begin
      pos_out = '0;
      oor_out = 1'b1;
    end else if (pos_s[W-2:POS_BITS] != '0) begin
      pos_out = '1;
      oor_out = 1'b1;
    end else begin
      pos_out = pos_s[POS_BITS-1:0];
      oor_out = 1'b0;
    end
  end

endmodule
